@@ hdl/kschash_pkg.sv @@
// kschash_pkg: types and constants shared by the key sequence code hasher
// used by kschash_step and key_sequence_code_hasher; no dependencies
`default_nettype none

package kschash_pkg;

   localparam int unsigned KeyCodeWidth = 16;
   localparam int unsigned TimeWidth    = 32;
   localparam int unsigned WordWidth    = 32;
   localparam int unsigned TimeoutWidth = 16;

   localparam logic [15:0] SINGLE_LIMIT  = 16'h006B;
   localparam logic [15:0] PAIR_LIMIT    = 16'h6B00;
   localparam logic [7:0]  BYTE_MASK     = 8'hFF;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [8:0]  NO_PREV_KEY   = 9'd511;
   localparam logic [7:0]  NO_HELD_KEY   = 8'd255;

   typedef struct packed {
      logic [WordWidth-1:0] key_sum;
      logic [WordWidth-1:0] hash_a;
      logic [WordWidth-1:0] hash_b;
      logic [8:0]           previous_key;
      logic [7:0]           held_single_key;
      logic [TimeWidth-1:0] last_key_time;
   } kschash_state_type;

   typedef struct packed {
      logic [KeyCodeWidth-1:0] key_code;
      logic [TimeWidth-1:0]    now_ms;
   } kschash_item_type;

   typedef struct packed {
      logic                 code_ready;
      logic [WordWidth-1:0] first_word;
      logic [WordWidth-1:0] second_word;
   } kschash_result_type;

endpackage

`default_nettype wire

@@ hdl/kschash_step.sv @@
// kschash_step: combinational update of hasher state and result for one key poll
// depends on kschash_pkg
`default_nettype none

module kschash_step
   import kschash_pkg::*;
(
   input  wire kschash_state_type       state,
   input  wire kschash_item_type        item,
   input  wire logic [TimeoutWidth-1:0] idle_timeout,
   output kschash_state_type            state_next,
   output kschash_result_type           result
);

   logic                 is_single;
   logic                 pair_reject;
   logic [7:0]           key;
   logic                 new_key;
   logic [WordWidth-1:0] hash_a_add;
   logic [WordWidth-1:0] hash_a_mix;
   logic [15:0]          key_square;
   logic [WordWidth-1:0] hash_b_mix;
   logic [TimeWidth-1:0] elapsed;
   logic                 timed_out;

   always_comb begin
      is_single   = item.key_code < SINGLE_LIMIT;
      pair_reject = !is_single && ((item.key_code > PAIR_LIMIT) ||
                    (item.key_code[15:8] != state.held_single_key));
      key         = item.key_code[7:0] & BYTE_MASK;
      new_key     = (key != 8'd0) && ({1'b0, key} != state.previous_key);

      hash_a_add  = state.hash_a + {13'd0, key, 11'd0};
      hash_a_mix  = (hash_a_add >> 17) + (hash_a_add << 4);
      key_square  = key * key;
      hash_b_mix  = (state.hash_b >> 29) + {16'd0, key_square} + (state.hash_b << 3);

      elapsed     = item.now_ms - state.last_key_time;
      timed_out   = elapsed > {16'd0, idle_timeout};

      state_next  = state;
      result      = '0;

      if (is_single) begin
         state_next.held_single_key = item.key_code[7:0];
      end

      if (pair_reject) begin
         // bad pair: drop sum and first hash, keep everything else
         state_next.key_sum = '0;
         state_next.hash_a  = '0;
      end else begin
         if (new_key) begin
            state_next.key_sum       = state.key_sum + {24'd0, key};
            state_next.hash_a        = hash_a_mix;
            state_next.hash_b        = hash_b_mix;
            state_next.last_key_time = item.now_ms;
         end else if (timed_out) begin
            result.code_ready  = 1'b1;
            result.first_word  = (state.hash_a >> 11) + (state.key_sum << 21);
            result.second_word = state.hash_b;
            state_next.key_sum = '0;
            state_next.hash_a  = '0;
            state_next.hash_b  = '0;
         end
         state_next.previous_key = {1'b0, key};
      end
   end

endmodule

`default_nettype wire

@@ hdl/key_sequence_code_hasher.sv @@
// key_sequence_code_hasher: input register, hasher state and result register
// depends on kschash_pkg and kschash_step
// an accepted req passes the input register and the result register to its rsp
// throughput: one transaction per cycle when rsp_tready does not stall; the state
//   update for a poll is done combinationally between the input and result registers
// reset: synchronous, active high; state registers take their idle values and the
//   timeout returns to 1000 ms, no clearing pass
`default_nettype none

module key_sequence_code_hasher
   import kschash_pkg::*;
(
   input  wire  logic        clock,
   input  wire  logic        reset,
   // req_tdata: key_code[15:0], now_ms[47:16]
   input  wire  logic        req_tvalid,
   output logic              req_tready,
   input  wire  logic [47:0] req_tdata,
   // rsp_tdata: first_word[31:0], second_word[63:32]
   // rsp_tuser: code_ready[0]
   output logic              rsp_tvalid,
   input  wire  logic        rsp_tready,
   output logic [63:0]       rsp_tdata,
   output logic              rsp_tuser,
   // csr_data: idle_timeout[15:0]
   input  wire  logic        csr_valid,
   output logic              csr_ready,
   input  wire  logic [15:0] csr_data
);

   logic                    in_valid_ff;
   kschash_item_type        in_item_ff;
   logic                    out_valid_ff;
   kschash_result_type      out_result_ff;
   kschash_state_type       state_ff;
   kschash_state_type       state_in;
   kschash_result_type      result_in;
   logic [TimeoutWidth-1:0] timeout_ff;
   logic                    out_free;
   logic                    advance;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;

   kschash_step u_step (
      .state        (state_ff),
      .item         (in_item_ff),
      .idle_timeout (timeout_ff),
      .state_next   (state_in),
      .result       (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                  <= 1'b0;
         out_valid_ff                 <= 1'b0;
         timeout_ff                   <= TIMEOUT_RESET;
         state_ff.key_sum             <= '0;
         state_ff.hash_a              <= '0;
         state_ff.hash_b              <= '0;
         state_ff.previous_key        <= NO_PREV_KEY;
         state_ff.held_single_key     <= NO_HELD_KEY;
         state_ff.last_key_time       <= '0;
      end else begin
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.key_code <= req_tdata[15:0];
         in_item_ff.now_ms   <= req_tdata[47:16];
      end
      if (advance) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_result_ff.second_word, out_result_ff.first_word};
   assign rsp_tuser  = out_result_ff.code_ready;

endmodule

`default_nettype wire
